FILE: rtl/fla_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Free list allocator package
// Shared widths, request and status codes, and the per-request decision type.
// ----------------------------------------------------------------------------
package fla_pkg;

  localparam int IDX_W       = 10;
  localparam int IDX_SPAN    = 1 << IDX_W;
  localparam int LIMIT_W     = 11;
  localparam int STATUS_W    = 2;
  localparam int CAPACITY_DEF = 1024;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1024);

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DUP   = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    granted;
    logic                pop;
    logic                push;
    logic                fresh;
  } fla_dec_t;

endpackage
`default_nettype wire

FILE: rtl/fla_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one allocate or free request.
// ----------------------------------------------------------------------------
interface fla_req_if;
  logic                     valid;
  logic                     ready;
  logic                     func;
  logic [fla_pkg::IDX_W-1:0] free_index;

  modport source (output valid, output func, output free_index, input ready);
  modport sink   (input valid, input func, input free_index, output ready);
endinterface
`default_nettype wire

FILE: rtl/fla_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one status and granted index per request.
// ----------------------------------------------------------------------------
interface fla_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [fla_pkg::STATUS_W-1:0] status;
  logic [fla_pkg::IDX_W-1:0]    granted_index;

  modport source (output valid, output status, output granted_index, input ready);
  modport sink   (input valid, input status, input granted_index, output ready);
endinterface
`default_nettype wire

FILE: rtl/fla_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port, one registered read port with write-first forwarding.
// ----------------------------------------------------------------------------
module fla_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 10,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= (we && (waddr == raddr)) ? wdata : mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

FILE: rtl/fla_clear.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Clearing sweep
// Walks every freed-bit address once after reset.
// ----------------------------------------------------------------------------
module fla_clear #(
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  output logic               busy,
  output logic      [AW-1:0] addr
);

  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic          busy_r;
  logic [AW-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      if (cnt_r == LAST) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  assign busy = busy_r;
  assign addr = cnt_r;

endmodule
`default_nettype wire

FILE: rtl/fla_decide.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Request decision
// Picks pop, fresh issue, push or reject for the registered request.
// ----------------------------------------------------------------------------
module fla_decide #(
  parameter int CAPACITY = fla_pkg::CAPACITY_DEF,
  localparam int CNT_W = $clog2(CAPACITY + 1)
) (
  input  wire logic                        func,
  input  wire logic [fla_pkg::IDX_W-1:0]   free_index,
  input  wire logic                        marked,
  input  wire logic [CNT_W-1:0]            count,
  input  wire logic [fla_pkg::LIMIT_W-1:0] fresh,
  input  wire logic [fla_pkg::LIMIT_W-1:0] entry_limit,
  input  wire logic [fla_pkg::IDX_W-1:0]   top,
  output fla_pkg::fla_dec_t                dec
);

  localparam int LW = (CNT_W > fla_pkg::LIMIT_W) ? CNT_W : fla_pkg::LIMIT_W;
  localparam logic [LW-1:0]    CAP_WIDE = LW'(CAPACITY);
  localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);

  logic [fla_pkg::LIMIT_W-1:0] eff_limit;

  assign eff_limit = (LW'(entry_limit) > CAP_WIDE) ? fla_pkg::LIMIT_W'(CAPACITY)
                                                   : entry_limit;

  always_comb begin
    dec        = '0;
    dec.status = fla_pkg::ST_OK;
    if (func == fla_pkg::FUNC_ALLOC) begin
      if (count != '0) begin
        dec.pop     = 1'b1;
        dec.granted = top;
      end else if (fresh >= eff_limit) begin
        dec.status = fla_pkg::ST_FULL;
      end else begin
        dec.fresh   = 1'b1;
        dec.granted = fresh[fla_pkg::IDX_W-1:0];
      end
    end else begin
      if ({1'b0, free_index} >= eff_limit) begin
        dec.status = fla_pkg::ST_RANGE;
      end else if (marked) begin
        dec.status = fla_pkg::ST_DUP;
      end else if (count < CAP_CNT) begin
        dec.push = 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/free_list_index_allocator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Free list index allocator
// Hands out slot indices from a LIFO free stack, then from a rising counter.
//
// in_chan carries a request: func selects allocate or free, free_index is the
// index returned by a free. out_chan carries one response per request: status
// and the granted index (zero unless an allocate succeeds). cfg_wr_en writes
// entry_limit from cfg_wr_data; write it only while no request is in flight.
// From the input transfer a request passes through the request register, where
// it sits while the freed bit is read, and then the response register. One
// request is taken every cycle while the response channel does not stall; the
// stack pointer and the freed-bit RAM are updated by each request before the
// next one decides. After reset the freed-bit RAM is swept clear, one entry
// per cycle, over all min(CAPACITY, 1024) entries; in_chan.ready stays low
// until the sweep ends. A stalled response holds in the output register; one
// more request waits in the request register, and then in_chan.ready drops.
// ----------------------------------------------------------------------------
module free_list_index_allocator_unit #(
  parameter int CAPACITY = fla_pkg::CAPACITY_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  fla_req_if.sink                          in_chan,
  fla_rsp_if.source                        out_chan,
  input  wire logic                        cfg_wr_en,
  input  wire logic [fla_pkg::LIMIT_W-1:0] cfg_wr_data
);

  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int SP_W       = $clog2(CAPACITY);
  localparam int MARK_DEPTH = (CAPACITY < fla_pkg::IDX_SPAN) ? CAPACITY : fla_pkg::IDX_SPAN;
  localparam int MK_W       = $clog2(MARK_DEPTH);

  logic [fla_pkg::LIMIT_W-1:0]  entry_limit_r;
  logic                         q_v_r;
  logic                         q_func_r;
  logic [fla_pkg::IDX_W-1:0]    q_idx_r;
  logic [CNT_W-1:0]             count_r;
  logic [CNT_W-1:0]             count_nxt;
  logic [fla_pkg::LIMIT_W-1:0]  fresh_r;
  logic [fla_pkg::LIMIT_W-1:0]  fresh_nxt;
  logic                         o_v_r;
  logic [fla_pkg::STATUS_W-1:0] o_status_r;
  logic [fla_pkg::IDX_W-1:0]    o_granted_r;

  logic                      clr_busy;
  logic [MK_W-1:0]           clr_addr;
  logic                      advance;
  logic                      accept;
  logic                      marked;
  logic [fla_pkg::IDX_W-1:0] top;
  fla_pkg::fla_dec_t         dec;

  logic            mk_we;
  logic [MK_W-1:0] mk_waddr;
  logic            mk_wdata;

  assign advance        = q_v_r && (!o_v_r || out_chan.ready);
  assign in_chan.ready  = !clr_busy && (!q_v_r || advance);
  assign accept         = in_chan.valid && in_chan.ready;

  fla_clear #(.DEPTH(MARK_DEPTH)) u_clear (
    .clk   (clk),
    .rst_n (rst_n),
    .busy  (clr_busy),
    .addr  (clr_addr)
  );

  fla_decide #(.CAPACITY(CAPACITY)) u_decide (
    .func        (q_func_r),
    .free_index  (q_idx_r),
    .marked      (marked),
    .count       (count_r),
    .fresh       (fresh_r),
    .entry_limit (entry_limit_r),
    .top         (top),
    .dec         (dec)
  );

  assign mk_we    = clr_busy || (advance && (dec.pop || dec.push));
  assign mk_waddr = clr_busy ? clr_addr
                  : (dec.pop ? top[MK_W-1:0] : q_idx_r[MK_W-1:0]);
  assign mk_wdata = !clr_busy && dec.push;

  fla_ram #(.DEPTH(MARK_DEPTH), .WIDTH(1)) u_mark_ram (
    .clk   (clk),
    .we    (mk_we),
    .waddr (mk_waddr),
    .wdata (mk_wdata),
    .re    (accept),
    .raddr (in_chan.free_index[MK_W-1:0]),
    .rdata (marked)
  );

  always_comb begin
    count_nxt = count_r;
    fresh_nxt = fresh_r;
    if (advance) begin
      if (dec.push) begin
        count_nxt = count_r + 1'b1;
      end else if (dec.pop) begin
        count_nxt = count_r - 1'b1;
      end
      if (dec.fresh) begin
        fresh_nxt = fresh_r + 1'b1;
      end
    end
  end

  fla_ram #(.DEPTH(CAPACITY), .WIDTH(fla_pkg::IDX_W)) u_stack_ram (
    .clk   (clk),
    .we    (advance && dec.push),
    .waddr (count_r[SP_W-1:0]),
    .wdata (q_idx_r),
    .re    (1'b1),
    .raddr (SP_W'(count_nxt - 1'b1)),
    .rdata (top)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_limit_r <= fla_pkg::LIMIT_RESET;
      q_v_r         <= 1'b0;
      o_v_r         <= 1'b0;
      count_r       <= '0;
      fresh_r       <= '0;
    end else begin
      if (cfg_wr_en) begin
        entry_limit_r <= cfg_wr_data;
      end
      if (accept) begin
        q_v_r <= 1'b1;
      end else if (advance) begin
        q_v_r <= 1'b0;
      end
      if (advance) begin
        o_v_r <= 1'b1;
      end else if (out_chan.ready) begin
        o_v_r <= 1'b0;
      end
      count_r <= count_nxt;
      fresh_r <= fresh_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_func_r <= in_chan.func;
      q_idx_r  <= in_chan.free_index;
    end
    if (advance) begin
      o_status_r  <= dec.status;
      o_granted_r <= dec.granted;
    end
  end

  assign out_chan.valid         = o_v_r;
  assign out_chan.status        = o_status_r;
  assign out_chan.granted_index = o_granted_r;

`ifndef ASSERT_OFF
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("free stack count exceeds capacity");

  a_reject_zero : assert property (@(posedge clk) disable iff (!rst_n)
    o_v_r && (o_status_r != fla_pkg::ST_OK) |-> o_granted_r == '0)
    else $error("rejected request carries a nonzero index");

  a_advance_out : assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> o_v_r && $past(dec.status) == o_status_r)
    else $error("decided request did not reach the response register");

  a_one_op : assert property (@(posedge clk) disable iff (!rst_n)
    q_v_r |-> !(dec.pop && dec.push) && !(dec.fresh && (dec.pop || dec.push)))
    else $error("more than one stack action for one request");

  a_no_take_clear : assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> !accept && !q_v_r)
    else $error("request taken during freed-bit sweep");
`endif

endmodule
`default_nettype wire

FILE: tb/tb_free_list_index_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Free list index allocator testbench
// Drives allocate and free requests over the request channel, predicts each
// status and granted index with a LIFO free-stack model kept in step with the
// accepted requests, and checks every response in order. The entry limit is
// changed between phases, and both channel ends idle and stall at random.
// ----------------------------------------------------------------------------
module tb_free_list_index_allocator_unit;

  localparam int SLOTS      = fla_pkg::CAPACITY_DEF;
  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic                      func;
    logic [fla_pkg::IDX_W-1:0] idx;
  } request_t;

  typedef struct packed {
    logic [fla_pkg::STATUS_W-1:0] status;
    logic [fla_pkg::IDX_W-1:0]    granted;
  } grant_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [fla_pkg::LIMIT_W-1:0] cfg_wr_data;

  fla_req_if in_chan ();
  fla_rsp_if out_chan ();

  free_list_index_allocator_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .out_chan   (out_chan),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  request_t request_q[$];
  grant_t   outcome_q[$];
  int       queued_total;
  int       checked_total;
  int       errors;
  int       quiet_cycles;
  int       send_idle_pct;
  int       rsp_stall_pct;
  logic     hold_go;
  logic     hold_rsp;

  // allocator image
  logic [fla_pkg::IDX_W-1:0]   stack_img [SLOTS];
  logic                        freed_img [SLOTS];
  int unsigned                 depth_img;
  int unsigned                 fresh_img;
  logic [fla_pkg::LIMIT_W-1:0] limit_img;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  function automatic grant_t grant_outcome(input logic fn,
                                           input logic [fla_pkg::IDX_W-1:0] idx);
    grant_t      g;
    int unsigned lim;
    lim = (limit_img > SLOTS) ? SLOTS : limit_img;
    g.status  = fla_pkg::ST_OK;
    g.granted = '0;
    if (fn == fla_pkg::FUNC_ALLOC) begin
      if (depth_img > 0) begin
        depth_img--;
        g.granted = stack_img[depth_img];
        freed_img[g.granted] = 1'b0;
      end else if (fresh_img >= lim) begin
        g.status = fla_pkg::ST_FULL;
      end else begin
        g.granted = fla_pkg::IDX_W'(fresh_img);
        fresh_img++;
      end
    end else begin
      if (idx >= lim) begin
        g.status = fla_pkg::ST_RANGE;
      end else if (freed_img[idx]) begin
        g.status = fla_pkg::ST_DUP;
      end else if (depth_img < SLOTS) begin
        stack_img[depth_img] = idx;
        depth_img++;
        freed_img[idx] = 1'b1;
      end
    end
    return g;
  endfunction

  // request driver
  always @(posedge clk) begin
    request_t r;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else if (!in_chan.valid || in_chan.ready) begin
      if (request_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        r = request_q.pop_front();
        in_chan.valid      <= 1'b1;
        in_chan.func       <= r.func;
        in_chan.free_index <= r.idx;
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // response receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= !hold_rsp && ($urandom_range(99) >= rsp_stall_pct);
    end
  end

  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_rsp <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rsp <= 1'b0;
  end

  // predictor and checker
  always @(posedge clk) begin
    grant_t g;
    if (!rst_n) begin
      depth_img = 0;
      fresh_img = 0;
      limit_img = fla_pkg::LIMIT_RESET;
      for (int i = 0; i < SLOTS; i++) begin
        freed_img[i] = 1'b0;
        stack_img[i] = '0;
      end
    end else begin
      if (cfg_wr_en) limit_img = cfg_wr_data;
      if (in_chan.valid && in_chan.ready) begin
        outcome_q.insert(outcome_q.size(), grant_outcome(in_chan.func, in_chan.free_index));
      end
      if (out_chan.valid && out_chan.ready) begin
        if (outcome_q.size() == 0) begin
          report("unexpected response, status", out_chan.status, -1);
        end else begin
          g = outcome_q.pop_front();
          if (out_chan.status !== g.status) report("status", out_chan.status, g.status);
          if (out_chan.granted_index !== g.granted) begin
            report("granted_index", out_chan.granted_index, g.granted);
          end
        end
        checked_total++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("free_list_index_allocator_unit test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_req(input logic fn, input int idx);
    request_t r;
    r.func = fn;
    r.idx  = fla_pkg::IDX_W'(idx);
    request_q.insert(request_q.size(), r);
    queued_total++;
  endtask

  task automatic queue_random(input int lim, input int alloc_pct, input int n);
    int hi;
    int pick;
    int idx;
    hi = (lim > SLOTS) ? SLOTS : lim;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        idx = (hi > 0) ? $urandom_range(hi - 1) : 0;
      end else if (pick < 80) begin
        idx = hi - 2 + $urandom_range(4);
        if (idx < 0) idx = 0;
        if (idx > SLOTS - 1) idx = SLOTS - 1;
      end else begin
        idx = $urandom_range(SLOTS - 1);
      end
      queue_req(($urandom_range(99) < alloc_pct) ? fla_pkg::FUNC_ALLOC : fla_pkg::FUNC_FREE,
                idx);
    end
  endtask

  task automatic drain;
    while (checked_total != queued_total) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input int value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= fla_pkg::LIMIT_W'(value);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic set_idling(input int send_pct, input int rsp_pct);
    @(posedge clk);
    send_idle_pct <= send_pct;
    rsp_stall_pct <= rsp_pct;
  endtask

  task automatic run_random(input int lim, input int alloc_pct, input int n,
                            input int send_pct, input int rsp_pct);
    drain();
    write_limit(lim);
    set_idling(send_pct, rsp_pct);
    queue_random(lim, alloc_pct, n);
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = '0;
    in_chan.valid      = 1'b0;
    in_chan.func       = fla_pkg::FUNC_ALLOC;
    in_chan.free_index = '0;
    out_chan.ready     = 1'b0;
    hold_go            = 1'b0;
    hold_rsp           = 1'b0;
    send_idle_pct      = 0;
    rsp_stall_pct      = 0;
    queued_total       = 0;
    checked_total      = 0;
    errors             = 0;
    quiet_cycles       = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // fresh indices, LIFO reuse, duplicate free, free of a never-issued index
    queue_req(fla_pkg::FUNC_ALLOC, 0);
    queue_req(fla_pkg::FUNC_ALLOC, 1023);
    queue_req(fla_pkg::FUNC_ALLOC, 0);
    queue_req(fla_pkg::FUNC_FREE, 1);
    queue_req(fla_pkg::FUNC_FREE, 1);
    queue_req(fla_pkg::FUNC_FREE, 1023);
    queue_req(fla_pkg::FUNC_ALLOC, 0);
    queue_req(fla_pkg::FUNC_ALLOC, 0);
    queue_req(fla_pkg::FUNC_ALLOC, 0);
    queue_req(fla_pkg::FUNC_FREE, 0);
    drain();

    // lowered limit: out of range, stack still pops, counter at the limit
    write_limit(4);
    queue_req(fla_pkg::FUNC_FREE, 4);
    queue_req(fla_pkg::FUNC_FREE, 1023);
    queue_req(fla_pkg::FUNC_ALLOC, 0);
    queue_req(fla_pkg::FUNC_ALLOC, 0);
    queue_req(fla_pkg::FUNC_FREE, 3);
    queue_req(fla_pkg::FUNC_ALLOC, 0);
    drain();

    // zero limit
    write_limit(0);
    queue_req(fla_pkg::FUNC_FREE, 0);
    queue_req(fla_pkg::FUNC_ALLOC, 0);
    drain();

    // limit above capacity
    write_limit(2047);
    queue_req(fla_pkg::FUNC_FREE, 1023);
    queue_req(fla_pkg::FUNC_ALLOC, 0);
    queue_req(fla_pkg::FUNC_ALLOC, 0);

    run_random(32, 60, 200, 0, 0);
    run_random(1, 50, 100, 83, 0);
    run_random(200, 55, 250, 0, 83);
    run_random(1024, 30, 300, 23, 23);
    run_random(2047, 70, 250, 0, 0);
    hold_go = 1'b1;
    run_random(7, 50, 150, 83, 83);

    drain();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("free_list_index_allocator_unit test passed");
    end else begin
      $display("free_list_index_allocator_unit test failed");
    end
    $finish;
  end

endmodule
